@@ hw/rtl/lr_pkg.sv @@
// lr_pkg: shared codes and constants for the line rasterizer
// no dependencies; imported by lr_back, line_rasterizer_with_offset and the bench
package lr_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_NEXT  = 1'b1
    } lr_op_t;

    typedef enum logic {
        REG_OFFSET_X = 1'b0,
        REG_OFFSET_Y = 1'b1
    } lr_reg_t;

    localparam int OFFSET_RESET = -200;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int QUEUE_DEPTH  = 2;

endpackage

@@ hw/rtl/lr_fifo.sv @@
// lr_fifo: small register queue with full/empty flags
// no dependencies; used for the command queue and the result queue
module lr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/lr_front.sv @@
// lr_front: classifies an input beat into a decoded line command
// no dependencies; feeds the command queue in line_rasterizer_with_offset
module lr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                         opcode,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         cmd_op,
    output logic signed [COORD_BITS-1:0] cmd_x0,
    output logic signed [COORD_BITS-1:0] cmd_y0,
    output logic        [COORD_BITS:0]   cmd_adx,
    output logic        [COORD_BITS:0]   cmd_ady,
    output logic                         cmd_ymaj,
    output logic                         cmd_ydown,
    output logic signed [COORD_BITS+2:0] cmd_err,
    output logic        [COORD_BITS:0]   cmd_steps
);
    logic                         swap;
    logic signed [COORD_BITS-1:0] x1, y1;
    logic signed [COORD_BITS:0]   dx, dy, neg_dy;
    logic        [COORD_BITS:0]   major, minor;

    always_comb
    begin
        swap   = (start_x > end_x);
        cmd_x0 = swap ? end_x   : start_x;
        cmd_y0 = swap ? end_y   : start_y;
        x1     = swap ? start_x : end_x;
        y1     = swap ? start_y : end_y;

        dx     = {x1[COORD_BITS-1], x1} - {cmd_x0[COORD_BITS-1], cmd_x0};
        dy     = {y1[COORD_BITS-1], y1} - {cmd_y0[COORD_BITS-1], cmd_y0};
        neg_dy = -dy;

        cmd_op    = opcode;
        cmd_ydown = dy[COORD_BITS];
        cmd_adx   = dx;
        cmd_ady   = cmd_ydown ? neg_dy : dy;
        cmd_ymaj  = (cmd_ady > cmd_adx);
        major     = cmd_ymaj ? cmd_ady : cmd_adx;
        minor     = cmd_ymaj ? cmd_adx : cmd_ady;
        cmd_steps = major;
        cmd_err   = $signed({1'b0, minor, 1'b0}) - $signed({2'b00, major});
    end

endmodule

@@ hw/rtl/lr_back.sv @@
// lr_back: line stepping engine with error term and offset translation
// depends on lr_pkg; reads the command queue and writes the result queue
module lr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_ready,
    input  logic                         cmd_op,
    input  logic signed [COORD_BITS-1:0] cmd_x0,
    input  logic signed [COORD_BITS-1:0] cmd_y0,
    input  logic        [COORD_BITS:0]   cmd_adx,
    input  logic        [COORD_BITS:0]   cmd_ady,
    input  logic                         cmd_ymaj,
    input  logic                         cmd_ydown,
    input  logic signed [COORD_BITS+2:0] cmd_err,
    input  logic        [COORD_BITS:0]   cmd_steps,
    input  logic                         res_full,
    input  logic signed [COORD_BITS-1:0] offset_x,
    input  logic signed [COORD_BITS-1:0] offset_y,
    output logic                         cmd_pop,
    output logic                         res_push,
    output logic signed [COORD_BITS:0]   res_px,
    output logic signed [COORD_BITS:0]   res_py,
    output logic                         res_valid,
    output logic                         res_last
);
    import lr_pkg::*;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic        [COORD_BITS:0]   adx_reg, adx_next;
    logic        [COORD_BITS:0]   ady_reg, ady_next;
    logic signed [COORD_BITS+2:0] err_reg, err_next;
    logic        [COORD_BITS:0]   steps_reg, steps_next;
    logic                         ymaj_reg, ymaj_next;
    logic                         ydown_reg, ydown_next;
    logic                         active_reg, active_next;

    logic                         minor_step;
    logic signed [COORD_BITS-1:0] y_inc, y_stepped;
    logic signed [COORD_BITS+2:0] two_adx, two_ady;

    assign cmd_pop  = cmd_ready && !res_full;
    assign res_push = cmd_pop;

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        adx_next    = adx_reg;
        ady_next    = ady_reg;
        err_next    = err_reg;
        steps_next  = steps_reg;
        ymaj_next   = ymaj_reg;
        ydown_next  = ydown_reg;
        active_next = active_reg;
        res_valid   = 1'b0;
        res_last    = 1'b0;

        minor_step = (err_reg > 0);
        y_inc      = ydown_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
        y_stepped  = cur_y_reg + y_inc;
        two_adx    = $signed({1'b0, adx_reg, 1'b0});
        two_ady    = $signed({1'b0, ady_reg, 1'b0});

        unique case (cmd_op)
            OP_START:
            begin
                cur_x_next  = cmd_x0;
                cur_y_next  = cmd_y0;
                adx_next    = cmd_adx;
                ady_next    = cmd_ady;
                err_next    = cmd_err;
                steps_next  = cmd_steps;
                ymaj_next   = cmd_ymaj;
                ydown_next  = cmd_ydown;
                active_next = (cmd_steps != '0);
                res_valid   = 1'b1;
                res_last    = (cmd_steps == '0);
            end
            OP_NEXT:
            begin
                if (active_reg)
                begin
                    if (ymaj_reg)
                    begin
                        cur_y_next = y_stepped;
                        cur_x_next = minor_step ? cur_x_reg + 1'b1 : cur_x_reg;
                        err_next   = err_reg + two_adx - (minor_step ? two_ady : '0);
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + 1'b1;
                        cur_y_next = minor_step ? y_stepped : cur_y_reg;
                        err_next   = err_reg + two_ady - (minor_step ? two_adx : '0);
                    end
                    steps_next  = steps_reg - 1'b1;
                    active_next = (steps_next != '0);
                    res_valid   = 1'b1;
                    res_last    = (steps_next == '0);
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        res_px = res_valid ? ({cur_x_next[COORD_BITS-1], cur_x_next}
                            + {offset_x[COORD_BITS-1], offset_x}) : '0;
        res_py = res_valid ? ({cur_y_next[COORD_BITS-1], cur_y_next}
                            + {offset_y[COORD_BITS-1], offset_y}) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            adx_reg    <= '0;
            ady_reg    <= '0;
            err_reg    <= '0;
            steps_reg  <= '0;
            ymaj_reg   <= 1'b0;
            ydown_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else if (cmd_pop)
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            adx_reg    <= adx_next;
            ady_reg    <= ady_next;
            err_reg    <= err_next;
            steps_reg  <= steps_next;
            ymaj_reg   <= ymaj_next;
            ydown_reg  <= ydown_next;
            active_reg <= active_next;
        end
    end

endmodule

@@ hw/rtl/line_rasterizer_with_offset.sv @@
// line_rasterizer_with_offset: top level of the line rasterizer
// depends on lr_pkg, lr_front, lr_fifo, lr_back
//
//   channel   handshake               beat contents
//   command   push / full             opcode, start_x, start_y, end_x, end_y
//   pixel     empty / pop             pixel_x, pixel_y, pixel_valid, last_pixel
//   config    psel/penable/pwrite     offset_x at 0x0, offset_y at 0x4
//
// one command beat in and one pixel beat out per cycle, sustained while pop is held high
// a pushed command is registered in the command queue, then its pixel in the pixel queue
// a two-entry command queue and a two-entry pixel queue part the sides
// the stepping engine stalls while the command queue is empty or the pixel queue is full
// reset empties both queues, clears the line state and loads offsets of -200
module line_rasterizer_with_offset #(
    parameter int COORD_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic                              opcode,
    input  logic signed [COORD_BITS-1:0]      start_x,
    input  logic signed [COORD_BITS-1:0]      start_y,
    input  logic signed [COORD_BITS-1:0]      end_x,
    input  logic signed [COORD_BITS-1:0]      end_y,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [COORD_BITS:0]        pixel_x,
    output logic signed [COORD_BITS:0]        pixel_y,
    output logic                              pixel_valid,
    output logic                              last_pixel
);
    import lr_pkg::*;

    localparam int CMD_W = 6 * COORD_BITS + 9;
    localparam int RES_W = 2 * COORD_BITS + 4;

    logic signed [COORD_BITS-1:0] offset_x_reg, offset_x_next;
    logic signed [COORD_BITS-1:0] offset_y_reg, offset_y_next;
    logic                         cfg_wr;
    logic                         cfg_sel;

    // config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[2];

    always_comb
    begin
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_OFFSET_X: offset_x_next = pwdata[COORD_BITS-1:0];
                REG_OFFSET_Y: offset_y_next = pwdata[COORD_BITS-1:0];
                default:      offset_x_next = offset_x_reg;
            endcase
        end
        unique case (cfg_sel)
            REG_OFFSET_X: prdata = {{(APB_DATA_W-COORD_BITS){offset_x_reg[COORD_BITS-1]}},
                                    offset_x_reg};
            REG_OFFSET_Y: prdata = {{(APB_DATA_W-COORD_BITS){offset_y_reg[COORD_BITS-1]}},
                                    offset_y_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= COORD_BITS'(OFFSET_RESET);
            offset_y_reg <= COORD_BITS'(OFFSET_RESET);
        end
        else
        begin
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
        end
    end

    // front: decode into the command queue
    logic                         f_op;
    logic signed [COORD_BITS-1:0] f_x0, f_y0;
    logic        [COORD_BITS:0]   f_adx, f_ady, f_steps;
    logic                         f_ymaj, f_ydown;
    logic signed [COORD_BITS+2:0] f_err;
    logic [CMD_W-1:0]             cmd_wdata, cmd_rdata;
    logic                         cmd_empty, cmd_pop;

    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .opcode    (opcode),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .cmd_op    (f_op),
        .cmd_x0    (f_x0),
        .cmd_y0    (f_y0),
        .cmd_adx   (f_adx),
        .cmd_ady   (f_ady),
        .cmd_ymaj  (f_ymaj),
        .cmd_ydown (f_ydown),
        .cmd_err   (f_err),
        .cmd_steps (f_steps)
    );

    assign cmd_wdata = {f_op, f_x0, f_y0, f_adx, f_ady, f_ymaj, f_ydown, f_err, f_steps};

    lr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_wdata),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rdata),
        .full    (full),
        .empty   (cmd_empty)
    );

    // back: stepping engine into the pixel queue
    logic                         q_op;
    logic signed [COORD_BITS-1:0] q_x0, q_y0;
    logic        [COORD_BITS:0]   q_adx, q_ady, q_steps;
    logic                         q_ymaj, q_ydown;
    logic signed [COORD_BITS+2:0] q_err;
    logic                         res_push, res_full;
    logic signed [COORD_BITS:0]   res_px, res_py;
    logic                         res_valid, res_last;
    logic [RES_W-1:0]             res_wdata, res_rdata;

    assign {q_op, q_x0, q_y0, q_adx, q_ady, q_ymaj, q_ydown, q_err, q_steps} = cmd_rdata;

    lr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ready (!cmd_empty),
        .cmd_op    (q_op),
        .cmd_x0    (q_x0),
        .cmd_y0    (q_y0),
        .cmd_adx   (q_adx),
        .cmd_ady   (q_ady),
        .cmd_ymaj  (q_ymaj),
        .cmd_ydown (q_ydown),
        .cmd_err   (q_err),
        .cmd_steps (q_steps),
        .res_full  (res_full),
        .offset_x  (offset_x_reg),
        .offset_y  (offset_y_reg),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res_px    (res_px),
        .res_py    (res_py),
        .res_valid (res_valid),
        .res_last  (res_last)
    );

    assign res_wdata = {res_px, res_py, res_valid, res_last};

    lr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wdata),
        .rd_en   (pop),
        .rd_data (res_rdata),
        .full    (res_full),
        .empty   (empty)
    );

    assign {pixel_x, pixel_y, pixel_valid, last_pixel} = res_rdata;

    // checks
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("pixel beat pushed into a full queue");

    a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from an empty queue");

    a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_pixel) |-> pixel_valid)
        else $error("last pixel flagged on an invalid beat");

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pixel_valid) |-> (pixel_x == '0 && pixel_y == '0))
        else $error("invalid beat carries a coordinate");

endmodule

@@ bench/line_rasterizer_with_offset_tb.sv @@
// line_rasterizer_with_offset_tb: self-checking bench for the offset line rasterizer
// drives command beats and apb offset writes, predicts every pixel beat and checks it
// depends on lr_pkg and line_rasterizer_with_offset
`timescale 1ns / 1ps

module line_rasterizer_with_offset_tb;

    import lr_pkg::*;

    localparam int CW            = 12;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;

    typedef struct {
        lr_op_t               op;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } cmd_t;

    typedef struct {
        logic signed [CW:0] px;
        logic signed [CW:0] py;
        logic               valid;
        logic               is_last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic push;
    logic full;
    logic opcode;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic empty;
    logic pop = 1'b0;
    logic signed [CW:0] pixel_x;
    logic signed [CW:0] pixel_y;
    logic pixel_valid;
    logic last_pixel;

    // predicted line state and offsets
    logic signed [CW-1:0] ln_x;
    logic signed [CW-1:0] ln_y;
    logic [CW:0]          ln_dx;
    logic [CW:0]          ln_dy;
    logic [CW:0]          ln_left;
    logic signed [14:0]   ln_err;
    logic                 ln_ymajor;
    logic                 ln_down;
    logic                 ln_active;
    logic signed [CW-1:0] off_x;
    logic signed [CW-1:0] off_y;

    pixel_t pending_pixels[$];

    int fails = 0;
    int cmd_count = 0;
    int start_count = 0;
    int beats_checked = 0;
    int cfg_count = 0;
    int cycle_count = 0;
    int pop_hold = 0;
    bit idle_on = 1'b0;

    line_rasterizer_with_offset #(
        .COORD_BITS(CW)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .push(push),
        .full(full),
        .opcode(opcode),
        .start_x(start_x),
        .start_y(start_y),
        .end_x(end_x),
        .end_y(end_y),
        .empty(empty),
        .pop(pop),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .pixel_valid(pixel_valid),
        .last_pixel(last_pixel)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic pixel_t emit_pixel(input logic is_last);
        pixel_t p;
        p.px      = (CW + 1)'(int'(ln_x) + int'(off_x));
        p.py      = (CW + 1)'(int'(ln_y) + int'(off_y));
        p.valid   = 1'b1;
        p.is_last = is_last;
        return p;
    endfunction

    function automatic pixel_t step_line(input cmd_t c);
        pixel_t p;
        int x0, y0, x1, y1, t, dy, e;
        p = '{default: '0};
        if (c.op == OP_START)
        begin
            x0 = int'(c.sx);
            y0 = int'(c.sy);
            x1 = int'(c.ex);
            y1 = int'(c.ey);
            if (x0 > x1)
            begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            dy        = y1 - y0;
            ln_x      = CW'(x0);
            ln_y      = CW'(y0);
            ln_dx     = (CW + 1)'(x1 - x0);
            ln_down   = dy < 0;
            ln_dy     = (CW + 1)'(ln_down ? -dy : dy);
            ln_ymajor = ln_dy > ln_dx;
            if (ln_ymajor)
            begin
                ln_left = ln_dy;
                e = 2 * int'(ln_dx) - int'(ln_dy);
            end
            else
            begin
                ln_left = ln_dx;
                e = 2 * int'(ln_dy) - int'(ln_dx);
            end
            ln_err    = 15'(e);
            ln_active = ln_left != 0;
            p = emit_pixel(ln_left == 0);
        end
        else if (ln_active)
        begin
            e = int'(ln_err);
            if (ln_ymajor)
            begin
                ln_y = ln_down ? ln_y - 1'b1 : ln_y + 1'b1;
                if (e > 0)
                begin
                    ln_x = ln_x + 1'b1;
                    e = e - 2 * int'(ln_dy);
                end
                e = e + 2 * int'(ln_dx);
            end
            else
            begin
                ln_x = ln_x + 1'b1;
                if (e > 0)
                begin
                    ln_y = ln_down ? ln_y - 1'b1 : ln_y + 1'b1;
                    e = e - 2 * int'(ln_dx);
                end
                e = e + 2 * int'(ln_dy);
            end
            ln_err    = 15'(e);
            ln_left   = ln_left - 1'b1;
            ln_active = ln_left != 0;
            p = emit_pixel(ln_left == 0);
        end
        return p;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 7))
            0: return -2048;
            1: return 2047;
            default: return int'($urandom_range(0, 4095)) - 2048;
        endcase
    endfunction

    function automatic int rand_near(input int c, input int span);
        return clamp_coord(c + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [APB_ADDR_W-1:0] reg_addr(input lr_reg_t r);
        return APB_ADDR_W'({r, 2'b00});
    endfunction

    // one command beat, with an optional random gap in front
    task automatic send_cmd(input cmd_t c);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        opcode  <= c.op;
        start_x <= c.sx;
        start_y <= c.sy;
        end_x   <= c.ex;
        end_y   <= c.ey;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_pixels.push_back(step_line(c));
        cmd_count++;
        if (c.op == OP_START)
            start_count++;
    endtask

    task automatic send_start(input int sx, input int sy, input int ex, input int ey);
        cmd_t c;
        c.op = OP_START;
        c.sx = CW'(sx);
        c.sy = CW'(sy);
        c.ex = CW'(ex);
        c.ey = CW'(ey);
        send_cmd(c);
    endtask

    // endpoint fields are ignored on next, so they carry junk
    task automatic send_next();
        cmd_t c;
        c.op = OP_NEXT;
        c.sx = CW'($urandom);
        c.sy = CW'($urandom);
        c.ex = CW'($urandom);
        c.ey = CW'($urandom);
        send_cmd(c);
    endtask

    task automatic wait_idle();
        int n;
        push <= 1'b0;
        n = 0;
        while (pending_pixels.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            $error("%0d pixel beats never arrived", pending_pixels.size());
            fails++;
            pending_pixels.delete();
        end
    endtask

    task automatic apb_write(input lr_reg_t r, input logic signed [CW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(r);
        pwdata  <= APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (r == REG_OFFSET_X)
            off_x = v;
        else
            off_y = v;
        @(posedge clk);
    endtask

    task automatic check_offset(input lr_reg_t r, input logic signed [CW-1:0] want);
        logic signed [CW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(r);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata[CW-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== want)
        begin
            $error("%s readback: expected %0d, got %0d", r.name(), want, got);
            fails++;
        end
    endtask

    task automatic set_offsets(input int x, input int y);
        apb_write(REG_OFFSET_X, CW'(x));
        apb_write(REG_OFFSET_Y, CW'(y));
        check_offset(REG_OFFSET_X, off_x);
        check_offset(REG_OFFSET_Y, off_y);
        cfg_count++;
    endtask

    task automatic test_reset_defaults();
        check_offset(REG_OFFSET_X, CW'(OFFSET_RESET));
        check_offset(REG_OFFSET_Y, CW'(OFFSET_RESET));
        send_next();
        send_start(0, 0, 0, 0);
        send_next();
        wait_idle();
    endtask

    task automatic test_line_shapes();
        // full-range diagonal, dropped by the next start
        send_start(-2048, 2047, 2047, -2048);
        send_next();
        // vertical, stepping down, order kept
        send_start(7, 3, 7, -1);
        repeat (4) send_next();
        // swapped endpoints
        send_start(5, 0, 1, 3);
        repeat (4) send_next();
        // equal dx and dy stays x-major
        send_start(0, 0, 2, -2);
        repeat (2) send_next();
        // y-major with an x step
        send_start(0, -2048, 1, -2046);
        repeat (2) send_next();
        wait_idle();
    endtask

    task automatic test_offset_extremes();
        int ox[3] = '{2047, -2048, 0};
        int oy[3] = '{2047, -2048, -1};
        for (int i = 0; i < 3; i++)
        begin
            wait_idle();
            set_offsets(ox[i], oy[i]);
            send_start(2047, 2047, 2047, 2047);
            send_start(-2048, -2048, -2048, -2048);
        end
        wait_idle();
    endtask

    task automatic test_random_lines(input int n_items);
        int goal, quiet_from, next_cfg, kind, sx, sy, span, cut, extra;
        cmd_t c;
        goal       = cmd_count + n_items;
        quiet_from = goal - 200;
        next_cfg   = cmd_count + 150;
        idle_on    = 1'b1;
        while (cmd_count < goal)
        begin
            if (cmd_count >= next_cfg)
            begin
                wait_idle();
                set_offsets(rand_coord(), rand_coord());
                next_cfg = cmd_count + 150;
                idle_on  = $urandom_range(0, 3) != 0;
            end
            if (cmd_count >= quiet_from)
                idle_on = 1'b0;
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                sx   = rand_coord();
                sy   = rand_coord();
                span = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
                send_start(sx, sy, rand_near(sx, span), rand_near(sy, span));
                cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8) : 5000;
                while (ln_active && cut > 0)
                begin
                    send_next();
                    cut--;
                end
                extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
                repeat (extra) send_next();
            end
            else if (kind < 83)
            begin
                send_start(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                repeat ($urandom_range(0, 40)) send_next();
            end
            else if (kind < 85)
            begin
                sx = rand_coord();
                sy = rand_coord();
                send_start(sx, sy, rand_near(sx, 150), rand_near(sy, 150));
                while (ln_active)
                    send_next();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    c.op = lr_op_t'($urandom_range(0, 1));
                    c.sx = CW'($urandom);
                    c.sy = CW'($urandom);
                    c.ex = CW'($urandom);
                    c.ey = CW'($urandom);
                    send_cmd(c);
                end
            end
        end
        wait_idle();
    endtask

    // pixel side: random pop stalls in bursts while idle_on is set
    always @(posedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            pop_hold <= $urandom_range(0, 17);
            pop      <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pop && !empty)
        begin
            beats_checked++;
            if (pending_pixels.size() == 0)
            begin
                $error("pixel beat with nothing expected: x %0d y %0d valid %0b last %0b",
                       pixel_x, pixel_y, pixel_valid, last_pixel);
                fails++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_x !== want.px)
                begin
                    $error("pixel_x: expected %0d, got %0d", want.px, pixel_x);
                    fails++;
                end
                if (pixel_y !== want.py)
                begin
                    $error("pixel_y: expected %0d, got %0d", want.py, pixel_y);
                    fails++;
                end
                if (pixel_valid !== want.valid)
                begin
                    $error("pixel_valid: expected %0b, got %0b", want.valid, pixel_valid);
                    fails++;
                end
                if (last_pixel !== want.is_last)
                begin
                    $error("last_pixel: expected %0b, got %0b", want.is_last, last_pixel);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run exceeded %0d cycles", CYCLE_LIMIT);
        $display("line_rasterizer_with_offset_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        push      = 1'b0;
        opcode    = OP_START;
        start_x   = '0;
        start_y   = '0;
        end_x     = '0;
        end_y     = '0;
        off_x     = CW'(OFFSET_RESET);
        off_y     = CW'(OFFSET_RESET);
        ln_x      = '0;
        ln_y      = '0;
        ln_dx     = '0;
        ln_dy     = '0;
        ln_left   = '0;
        ln_err    = '0;
        ln_ymajor = 1'b0;
        ln_down   = 1'b0;
        ln_active = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;
        test_reset_defaults();
        test_line_shapes();
        test_offset_extremes();
        test_random_lines(1500);
        $display("sent %0d command beats (%0d line starts) under %0d offset settings",
                 cmd_count, start_count, cfg_count + 1);
        $display("checked %0d pixel beats with random stalls on both sides", beats_checked);
        if (fails == 0)
            $display("line_rasterizer_with_offset_tb: PASS");
        else
            $display("line_rasterizer_with_offset_tb: FAIL");
        $finish;
    end

endmodule
